// File: rtl/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// shared types and constants of the sorted record table
// ----------------------------------------------------------------------------
package srt_pkg;

   localparam int DEPTH = 256;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int GRP_SIZE = 16;
   localparam int NGRP = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;

   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_APPEND = 3'd1,
      OP_REMOVE = 3'd2,
      OP_READ   = 3'd3,
      OP_SEARCH = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_ERR  = 2'd1,
      STATUS_MISS = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_EVAL
   } state_type;

   typedef struct packed {
      logic [31:0] key;
      logic [15:0] cnt;
      logic [31:0] handle;
   } rec_type;

   typedef struct packed {
      logic             ins;
      logic             rem;
      logic [IDX_W-1:0] at;
      rec_type          wr;
      logic [IDX_W-1:0] probe;
   } cell_cmd_type;

endpackage

// File: rtl/srt_cell.sv
// ----------------------------------------------------------------------------
// srt_cell
// one table slot: holds a record, shifts with its neighbours, answers probes
// ----------------------------------------------------------------------------
module srt_cell (
   input  logic                        clock,
   input  logic [srt_pkg::IDX_W-1:0]   cell_pos,
   input  srt_pkg::cell_cmd_type       cmd,
   input  srt_pkg::rec_type            left_rec,
   input  srt_pkg::rec_type            right_rec,
   output srt_pkg::rec_type            rec,
   output srt_pkg::rec_type            sel
);
   import srt_pkg::*;

   rec_type rec_ff;
   rec_type rec_in;
   rec_type sel_ff;
   rec_type sel_in;

   always_comb begin
      rec_in = rec_ff;
      if (cmd.ins) begin
         if (cell_pos > cmd.at) begin
            rec_in = left_rec;
         end else if (cell_pos == cmd.at) begin
            rec_in = cmd.wr;
         end
      end else if (cmd.rem) begin
         if (cell_pos >= cmd.at) begin
            rec_in = right_rec;
         end
      end
      sel_in = (cell_pos == cmd.probe) ? rec_ff : '0;
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      sel_ff <= sel_in;
   end

   assign rec = rec_ff;
   assign sel = sel_ff;

endmodule

// File: rtl/sorted_record_table.sv
// ----------------------------------------------------------------------------
// sorted_record_table
// fixed-depth record table with shifting insert/remove and binary search
// ----------------------------------------------------------------------------
// The table is a row of DEPTH cells. Insert, append and remove shift the row
// as the transaction is taken and answer in the cycle after it is taken.
// A read or a search probe passes the registered probe broadcast, cell select
// and grouped OR tree before it is evaluated; a search repeats the probe once
// per halving of the range until the key is found or the range is empty.
// One transaction is in work at a time; a new one is taken once the previous
// result has been delivered.
module sorted_record_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [8:0]  req_index,
   input  logic [31:0] req_customer_asn,
   input  logic [15:0] req_provider_count,
   input  logic [31:0] req_provider_ref,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_found_asn,
   output logic [15:0] rsp_found_count,
   output logic [31:0] rsp_found_ref,
   output logic [7:0]  rsp_found_index,
   output logic [8:0]  rsp_count_now
);
   import srt_pkg::*;

   localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

   state_type        state_ff, state_in;
   logic             wait_ff, wait_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [IDX_W-1:0] probe_ff, probe_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] right_ff, right_in;
   logic [31:0]      key_ff, key_in;
   logic             search_ff, search_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       status_ff, status_in;
   rec_type          found_ff, found_in;
   logic [7:0]       fidx_ff, fidx_in;

   cell_cmd_type     cmd;
   rec_type          recs [DEPTH];
   rec_type          sels [DEPTH];
   rec_type          grp_ff [NGRP];
   rec_type          grp_in [NGRP];
   rec_type          probe_rec;

   logic [CMP_W-1:0] total_x;
   logic [CMP_W-1:0] index_x;
   logic [CNT_W:0]   mid_sum;
   logic [IDX_W-1:0] mid_next;
   logic [IDX_W-1:0] ins_at;
   logic             ins_err;
   logic [CNT_W-1:0] new_left;
   logic [CNT_W-1:0] new_right;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         srt_cell u_cell (
            .clock     (clock),
            .cell_pos  (IDX_W'(gi)),
            .cmd       (cmd),
            .left_rec  ((gi == 0) ? cmd.wr : recs[(gi == 0) ? 0 : gi - 1]),
            .right_rec ((gi == DEPTH - 1) ? recs[gi]
                                          : recs[(gi == DEPTH - 1) ? gi : gi + 1]),
            .rec       (recs[gi]),
            .sel       (sels[gi])
         );
      end
   endgenerate

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GRP_SIZE; k++) begin
            if (g * GRP_SIZE + k < DEPTH) begin
               grp_in[g] = grp_in[g] | sels[g * GRP_SIZE + k];
            end
         end
      end
      probe_rec = '0;
      for (int g = 0; g < NGRP; g++) begin
         probe_rec = probe_rec | grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NGRP; g++) begin
         grp_ff[g] <= grp_in[g];
      end
   end

   assign total_x = CMP_W'(total_ff);
   assign index_x = CMP_W'(req_index);

   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      total_in     = total_ff;
      probe_in     = probe_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      key_in       = key_ff;
      search_in    = search_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      fidx_in      = fidx_ff;

      cmd          = '0;
      cmd.probe    = probe_ff;
      cmd.wr.key   = req_customer_asn;
      cmd.wr.cnt   = req_provider_count;
      cmd.wr.handle = (req_provider_count != 16'd0) ? req_provider_ref : 32'd0;

      ins_at   = (req_operation == OP_APPEND) ? total_ff[IDX_W-1:0]
                                              : req_index[IDX_W-1:0];
      ins_err  = (total_x >= CMP_W'(DEPTH))
              || ((req_operation == OP_INSERT) && (index_x > total_x))
              || ((req_provider_count != 16'd0) && (req_provider_ref == 32'd0));
      cmd.at   = (req_operation == OP_REMOVE) ? req_index[IDX_W-1:0] : ins_at;

      mid_sum   = '0;
      mid_next  = '0;
      new_left  = '0;
      new_right = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               found_in = '0;
               fidx_in  = '0;
               unique case (req_operation)
                  OP_INSERT, OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (ins_err) begin
                        status_in = STATUS_ERR;
                     end else begin
                        status_in = STATUS_OK;
                        cmd.ins   = 1'b1;
                        total_in  = total_ff + CNT_W'(1);
                     end
                  end
                  OP_REMOVE: begin
                     rsp_valid_in = 1'b1;
                     if (index_x >= total_x) begin
                        status_in = STATUS_MISS;
                     end else begin
                        status_in = STATUS_OK;
                        cmd.rem   = 1'b1;
                        total_in  = total_ff - CNT_W'(1);
                     end
                  end
                  OP_READ: begin
                     if (index_x >= total_x) begin
                        rsp_valid_in = 1'b1;
                        status_in    = STATUS_MISS;
                     end else begin
                        search_in = 1'b0;
                        probe_in  = req_index[IDX_W-1:0];
                        wait_in   = 1'b0;
                        state_in  = ST_WAIT;
                     end
                  end
                  OP_SEARCH: begin
                     if (total_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        status_in    = STATUS_MISS;
                     end else begin
                        search_in = 1'b1;
                        key_in    = req_customer_asn;
                        left_in   = '0;
                        right_in  = total_ff - CNT_W'(1);
                        mid_sum   = {1'b0, total_ff - CNT_W'(1)};
                        probe_in  = mid_sum[IDX_W:1];
                        wait_in   = 1'b0;
                        state_in  = ST_WAIT;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     status_in    = STATUS_ERR;
                  end
               endcase
            end
         end
         ST_WAIT: begin
            if (wait_ff) begin
               state_in = ST_EVAL;
            end else begin
               wait_in = 1'b1;
            end
         end
         ST_EVAL: begin
            if (!search_ff || (probe_rec.key == key_ff)) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_OK;
               found_in     = probe_rec;
               fidx_in      = 8'(probe_ff);
               state_in     = ST_IDLE;
            end else begin
               new_left  = left_ff;
               new_right = right_ff;
               if (probe_rec.key < key_ff) begin
                  new_left = CNT_W'(probe_ff) + CNT_W'(1);
               end else begin
                  new_right = CNT_W'(probe_ff) - CNT_W'(1);
               end
               if (((probe_rec.key > key_ff) && (probe_ff == '0))
                   || (new_left > new_right)) begin
                  rsp_valid_in = 1'b1;
                  status_in    = STATUS_MISS;
                  state_in     = ST_IDLE;
               end else begin
                  left_in  = new_left;
                  right_in = new_right;
                  mid_sum  = {1'b0, new_left} + {1'b0, new_right};
                  mid_next = mid_sum[IDX_W:1];
                  probe_in = mid_next;
                  wait_in  = 1'b0;
                  state_in = ST_WAIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wait_ff   <= wait_in;
      probe_ff  <= probe_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      key_ff    <= key_in;
      search_ff <= search_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      fidx_ff   <= fidx_in;
   end

   assign req_ready       = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_asn   = found_ff.key;
   assign rsp_found_count = found_ff.cnt;
   assign rsp_found_ref   = found_ff.handle;
   assign rsp_found_index = fidx_ff;
   assign rsp_count_now   = 9'(total_ff);

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(DEPTH))
      else $error("record count beyond depth");

   a_eval_after_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> ($past(state_ff) == ST_WAIT))
      else $error("probe evaluated without settling");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("result shown while transaction still in work");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> $stable(total_ff))
      else $error("record count changed during a probe");

endmodule
